>>> rtl/lsc_pkg.sv
package lsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int MAX_PASSES = 8;
    localparam int PASS_BITS  = $clog2(MAX_PASSES + 1);
    localparam int DCNT_BITS  = $clog2(PROD_BITS + 1);
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic [3:0]                   code_t;

    localparam code_t CODE_L = 4'd8;
    localparam code_t CODE_R = 4'd4;
    localparam code_t CODE_B = 4'd2;
    localparam code_t CODE_T = 4'd1;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_BOTTOM = 2'd1,
        REG_RIGHT  = 2'd2,
        REG_TOP    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_UPDATE,
        S_EMIT
    } state_t;

    typedef struct packed {
        coord_t left;
        coord_t bottom;
        coord_t right;
        coord_t top;
    } window_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic mul;
        logic div_start;
        logic update;
        logic emit;
        logic emit_accept;
    } cmd_t;

    typedef struct packed {
        logic both_in;
        logic share;
        logic div_done;
    } status_t;

    function automatic code_t region(coord_t x, coord_t y, window_t w);
        code_t c;
        c = '0;
        if (x < w.left)   c = c | CODE_L;
        if (x > w.right)  c = c | CODE_R;
        if (y < w.bottom) c = c | CODE_B;
        if (y > w.top)    c = c | CODE_T;
        return c;
    endfunction

endpackage

>>> rtl/lsc_div.sv
module lsc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lsc_pkg::PROD_BITS-1:0] dividend,
    input  logic [lsc_pkg::DIFF_BITS-1:0] divisor,
    output logic                          done,
    output logic [lsc_pkg::PROD_BITS-1:0] quotient
);
    import lsc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic [PROD_BITS-1:0] dvd_reg, dvd_next;
    logic [DIFF_BITS-1:0] dsr_reg, dsr_next;
    logic [DIFF_BITS-1:0] rem_reg, rem_next;
    logic [DIFF_BITS:0]   rem_sh;
    logic [DIFF_BITS:0]   rem_sub;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, dvd_reg[PROD_BITS-1]};
        rem_sub   = rem_sh - {1'b0, dsr_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_BITS'(PROD_BITS);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sub[DIFF_BITS-1:0];
                dvd_next = {dvd_reg[PROD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIFF_BITS-1:0];
                dvd_next = {dvd_reg[PROD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> rtl/lsc_dp.sv
module lsc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  lsc_pkg::cmd_t    cmd,
    output lsc_pkg::status_t status,
    input  lsc_pkg::window_t win,
    input  lsc_pkg::coord_t  start_x,
    input  lsc_pkg::coord_t  start_y,
    input  lsc_pkg::coord_t  end_x,
    input  lsc_pkg::coord_t  end_y,
    output logic             accepted,
    output lsc_pkg::coord_t  clipped_start_x,
    output lsc_pkg::coord_t  clipped_start_y,
    output lsc_pkg::coord_t  clipped_end_x,
    output lsc_pkg::coord_t  clipped_end_y
);
    import lsc_pkg::*;

    coord_t x0_reg, y0_reg, x1_reg, y1_reg;
    diff_t  mula_reg, mulb_reg, dsr_reg;
    coord_t base_reg, fix_reg;
    logic   tb_reg, pt1_reg, neg_reg, zdiv_reg;
    prod_t  prod_reg;
    logic   acc_reg;
    coord_t ox0_reg, oy0_reg, ox1_reg, oy1_reg;

    code_t  c0, c1, csel;
    diff_t  dx, dy, sa, sb, sc;
    coord_t sbase, sfix;
    logic   stb;
    logic [PROD_BITS-1:0] div_dvd;
    logic [DIFF_BITS-1:0] div_dsr;
    logic [PROD_BITS-1:0] quo;
    logic                 div_done;
    logic signed [DIFF_BITS:0] qs, newc;
    coord_t nx, ny;

    assign c0 = region(x0_reg, y0_reg, win);
    assign c1 = region(x1_reg, y1_reg, win);

    assign status.both_in  = (c0 == '0) && (c1 == '0);
    assign status.share    = (c0 & c1) != '0;
    assign status.div_done = div_done;

    // edge choice: top, bottom, left, right
    always_comb
    begin
        csel  = (c0 != '0) ? c0 : c1;
        dx    = DIFF_BITS'(x1_reg) - DIFF_BITS'(x0_reg);
        dy    = DIFF_BITS'(y1_reg) - DIFF_BITS'(y0_reg);
        stb   = 1'b1;
        sa    = dx;
        sb    = DIFF_BITS'(win.top) - DIFF_BITS'(y0_reg);
        sc    = dy;
        sbase = x0_reg;
        sfix  = win.top;
        if ((csel & CODE_T) != '0)
        begin
            sb   = DIFF_BITS'(win.top) - DIFF_BITS'(y0_reg);
            sfix = win.top;
        end
        else if ((csel & CODE_B) != '0)
        begin
            sb   = DIFF_BITS'(win.bottom) - DIFF_BITS'(y0_reg);
            sfix = win.bottom;
        end
        else if ((csel & CODE_L) != '0)
        begin
            stb   = 1'b0;
            sa    = dy;
            sb    = DIFF_BITS'(win.left) - DIFF_BITS'(x0_reg);
            sc    = dx;
            sbase = y0_reg;
            sfix  = win.left;
        end
        else
        begin
            stb   = 1'b0;
            sa    = dy;
            sb    = DIFF_BITS'(win.right) - DIFF_BITS'(x0_reg);
            sc    = dx;
            sbase = y0_reg;
            sfix  = win.right;
        end
    end

    assign div_dvd = prod_reg[PROD_BITS-1] ? PROD_BITS'(-prod_reg) : PROD_BITS'(prod_reg);
    assign div_dsr = dsr_reg[DIFF_BITS-1] ? DIFF_BITS'(-dsr_reg) : DIFF_BITS'(dsr_reg);

    lsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (quo)
    );

    // quotient never exceeds the span, so the low bits hold it
    always_comb
    begin
        qs = '0;
        if (!zdiv_reg)
            qs = neg_reg ? -$signed({2'b00, quo[DIFF_BITS-2:0]})
                         :  $signed({2'b00, quo[DIFF_BITS-2:0]});
        newc = (DIFF_BITS+1)'(base_reg) + qs;
        nx   = tb_reg ? COORD_BITS'(newc) : fix_reg;
        ny   = tb_reg ? fix_reg : COORD_BITS'(newc);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg <= start_x;
            y0_reg <= start_y;
            x1_reg <= end_x;
            y1_reg <= end_y;
        end
        else if (cmd.update)
        begin
            if (pt1_reg)
            begin
                x1_reg <= nx;
                y1_reg <= ny;
            end
            else
            begin
                x0_reg <= nx;
                y0_reg <= ny;
            end
        end
        if (cmd.setup)
        begin
            mula_reg <= sa;
            mulb_reg <= sb;
            dsr_reg  <= sc;
            base_reg <= sbase;
            fix_reg  <= sfix;
            tb_reg   <= stb;
            pt1_reg  <= (c0 == '0);
            neg_reg  <= sa[DIFF_BITS-1] ^ sb[DIFF_BITS-1] ^ sc[DIFF_BITS-1];
            zdiv_reg <= (sc == '0);
        end
        if (cmd.mul)
            prod_reg <= PROD_BITS'(mula_reg) * PROD_BITS'(mulb_reg);
        if (cmd.emit)
        begin
            acc_reg <= cmd.emit_accept;
            ox0_reg <= cmd.emit_accept ? x0_reg : '0;
            oy0_reg <= cmd.emit_accept ? y0_reg : '0;
            ox1_reg <= cmd.emit_accept ? x1_reg : '0;
            oy1_reg <= cmd.emit_accept ? y1_reg : '0;
        end
    end

    assign accepted        = acc_reg;
    assign clipped_start_x = ox0_reg;
    assign clipped_start_y = oy0_reg;
    assign clipped_end_x   = ox1_reg;
    assign clipped_end_y   = oy1_reg;

endmodule

>>> rtl/lsc_ctrl.sv
module lsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lsc_pkg::status_t status,
    output lsc_pkg::cmd_t    cmd
);
    import lsc_pkg::*;

    state_t               state_reg, state_next;
    logic [PASS_BITS-1:0] pass_reg, pass_next;
    logic                 acc_reg, acc_next;
    logic                 ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        acc_next   = acc_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pass_next  = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (status.both_in)
                begin
                    acc_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (status.share || pass_reg == PASS_BITS'(MAX_PASSES))
                begin
                    acc_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                pass_next  = pass_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_accept = acc_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        ov_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= '0;
            acc_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            acc_reg   <= acc_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

>>> rtl/line_segment_window_clipper.sv
// Cohen-Sutherland segment clipper against a programmable rectangular window.
//
// Input channel (in_valid/in_ready) takes one word: a segment given by its two
// endpoints. Output channel (out_valid/out_ready) returns one word per input:
// the accept flag and the clipped endpoints, all zero when rejected.
// Window edges are set over the APB port (left, bottom, right, top at byte
// offsets 0, 4, 8, 12); write them only while the clipper is idle.
//
// A segment settled by the outcode test alone goes through load, outcode check
// and emit. Every clip pass runs setup, multiply, divider start, the restoring
// divide in lsc_div until its done strobe, update and an outcode recheck.
// At most 8 passes; typical segments need 0 to 4.
// One segment is in flight at a time, and every clip pass reuses the single divider.
//
// Reset (rst_n, async low) returns the window to 0/0/649/649 and empties the
// output register. A stalled receiver holds the result in the output register;
// the next segment is still accepted and processed, and it waits to be emitted
// until the pending word is taken.
module line_segment_window_clipper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [lsc_pkg::DATA_BITS-1:0] pwdata,
    output logic [lsc_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lsc_pkg::coord_t               start_x,
    input  lsc_pkg::coord_t               start_y,
    input  lsc_pkg::coord_t               end_x,
    input  lsc_pkg::coord_t               end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output lsc_pkg::coord_t               clipped_start_x,
    output lsc_pkg::coord_t               clipped_start_y,
    output lsc_pkg::coord_t               clipped_end_x,
    output lsc_pkg::coord_t               clipped_end_y
);
    import lsc_pkg::*;

    window_t  win_reg, win_next;
    cfg_reg_t reg_sel;
    coord_t   rd_val;
    cmd_t     cmd;
    status_t  status;

    // register select from the word address
    assign reg_sel = cfg_reg_t'(paddr[3:2]);

    always_comb
    begin
        win_next = win_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_LEFT:   win_next.left   = COORD_BITS'(pwdata);
                REG_BOTTOM: win_next.bottom = COORD_BITS'(pwdata);
                REG_RIGHT:  win_next.right  = COORD_BITS'(pwdata);
                REG_TOP:    win_next.top    = COORD_BITS'(pwdata);
                default:    win_next = win_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LEFT:   rd_val = win_reg.left;
            REG_BOTTOM: rd_val = win_reg.bottom;
            REG_RIGHT:  rd_val = win_reg.right;
            REG_TOP:    rd_val = win_reg.top;
            default:    rd_val = '0;
        endcase
    end

    // reads return the sign-extended coordinate
    assign prdata = DATA_BITS'(rd_val);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.left   <= COORD_BITS'(0);
            win_reg.bottom <= COORD_BITS'(0);
            win_reg.right  <= COORD_BITS'(649);
            win_reg.top    <= COORD_BITS'(649);
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    lsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lsc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .win             (win_reg),
        .start_x         (start_x),
        .start_y         (start_y),
        .end_x           (end_x),
        .end_y           (end_y),
        .accepted        (accepted),
        .clipped_start_x (clipped_start_x),
        .clipped_start_y (clipped_start_y),
        .clipped_end_x   (clipped_end_x),
        .clipped_end_y   (clipped_end_y)
    );

endmodule

>>> rtl/lsc_checker.sv
module lsc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            accepted,
    input lsc_pkg::coord_t clipped_start_x,
    input lsc_pkg::coord_t clipped_start_y,
    input lsc_pkg::coord_t clipped_end_x,
    input lsc_pkg::coord_t clipped_end_y
);

    // a pending word holds until taken (flag, start x and end y are checked)
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted)
            && $stable(clipped_start_x) && $stable(clipped_end_y))
        else $error("output word changed while stalled");

    // rejected words carry zero endpoints
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> clipped_start_x == '0 && clipped_start_y == '0
            && clipped_end_x == '0 && clipped_end_y == '0)
        else $error("rejected word with nonzero endpoints");

    // one segment at a time: busy right after taking one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second segment taken back to back");

    // no result appears sooner than the outcode test allows
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result emitted too early");

endmodule

bind line_segment_window_clipper lsc_checker u_lsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .clipped_start_x (clipped_start_x),
    .clipped_start_y (clipped_start_y),
    .clipped_end_x   (clipped_end_x),
    .clipped_end_y   (clipped_end_y)
);
